@@ hdl/rfid_ascii_hex_frame_parser_top_defines.svh @@
// assertion macros for the rfid frame parser checker
// depends on i_clk and i_rst_n being visible where a macro is used
`ifndef RFID_ASCII_HEX_FRAME_PARSER_TOP_DEFINES_SVH
`define RFID_ASCII_HEX_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define RFID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rfid frame parser: same-cycle check failed");

// next-cycle implication, off during reset
`define RFID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rfid frame parser: next-cycle check failed");

// state right after a reset cycle
`define RFID_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("rfid frame parser: post-reset check failed");

`endif

@@ hdl/rfid_hex_pkg.sv @@
// types, constants and the nibble decode for the rfid ascii-hex frame parser
// no dependencies
package rfid_hex_pkg;

    // framing bytes
    localparam logic [7:0] START_BYTE    = 8'h02;
    localparam logic [7:0] END_BYTE      = 8'h03;

    // ascii hex decode
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] ALPHA_OFFSET  = 8'h37;
    localparam logic [7:0] DIGIT_OFFSET  = 8'h30;

    // frame layout
    localparam int         BYTE_COUNT    = 5;
    localparam int         BYTE_IDX_W    = $clog2(BYTE_COUNT);

    // frame position codes: 0..10 next character, 11 end byte due, 15 idle
    localparam logic [3:0] POS_FIRST     = 4'd0;
    localparam logic [3:0] POS_END       = 4'd11;
    localparam logic [3:0] POS_WAIT      = 4'd15;

    // frame status codes
    localparam logic       STATUS_OK      = 1'b0;
    localparam logic       STATUS_BAD_END = 1'b1;

    typedef struct packed {
        logic        frame_status;
        logic [31:0] tag_id;
        logic [7:0]  xor_check;
    } t_frame;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_res_beat;

    // one ascii character to its value, wrapping mod 256
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        hex_value = (c > CHAR_NINE) ? (c - ALPHA_OFFSET) : (c - DIGIT_OFFSET);
    endfunction

endpackage

@@ hdl/rfid_hex_byte_if.sv @@
// valid/ready channel carrying one received reader byte per beat
// depends on nothing
interface rfid_hex_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/rfid_hex_frame_if.sv @@
// valid/ready channel carrying one parsed frame result per beat
// depends on nothing
interface rfid_hex_frame_if;
    logic        valid;
    logic        ready;
    logic        frame_status;
    logic [31:0] tag_id;
    logic [7:0]  xor_check;

    modport source (output valid, output frame_status, output tag_id, output xor_check,
                    input ready);
    modport sink   (input valid, input frame_status, input tag_id, input xor_check,
                    output ready);
endinterface

@@ hdl/rfid_hex_in_reg.sv @@
// input register stage: holds one received byte until the parser takes it
// depends on rfid_hex_pkg and rfid_hex_byte_if
module rfid_hex_in_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    rfid_hex_byte_if.sink          i_rx,
    input  logic                   i_advance,
    output rfid_hex_pkg::t_in_beat o_beat
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       accept;

    // free slot, or the held beat moves on this cycle
    assign i_rx.ready = !r_valid || i_advance;
    assign accept     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload load
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_beat.valid   = r_valid;
    assign o_beat.rx_byte = r_byte;

endmodule

@@ hdl/rfid_hex_parse.sv @@
// frame parser core: position tracking, nibble pairing and result build
// depends on rfid_hex_pkg
module rfid_hex_parse (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  rfid_hex_pkg::t_in_beat  i_beat,
    output rfid_hex_pkg::t_res_beat o_res
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [7:0] r_bytes [rfid_hex_pkg::BYTE_COUNT];

    logic                              step;
    logic [7:0]                        nib;
    logic [rfid_hex_pkg::BYTE_IDX_W-1:0] idx;
    logic                              store;
    logic [7:0]                        n_byte;
    logic [7:0]                        xor_all;

    assign step = i_advance && i_beat.valid;
    assign nib  = rfid_hex_pkg::hex_value(i_beat.rx_byte);
    assign idx  = r_pos[rfid_hex_pkg::BYTE_IDX_W:1];

    // character positions 0..9 land in a byte, the eleventh is dropped
    assign store = (r_pos < rfid_hex_pkg::POS_END) &&
                   (idx < rfid_hex_pkg::BYTE_IDX_W'(rfid_hex_pkg::BYTE_COUNT));

    // high nibble overwrites, low nibble adds mod 256
    assign n_byte = r_pos[0] ? (r_bytes[idx] + nib) : {nib[3:0], 4'h0};

    // next position
    always_comb begin
        if (r_pos < rfid_hex_pkg::POS_END) begin
            n_pos = r_pos + 4'd1;
        end else if (r_pos == rfid_hex_pkg::POS_END) begin
            n_pos = rfid_hex_pkg::POS_WAIT;
        end else if (i_beat.rx_byte == rfid_hex_pkg::START_BYTE) begin
            n_pos = rfid_hex_pkg::POS_FIRST;
        end else begin
            n_pos = rfid_hex_pkg::POS_WAIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= rfid_hex_pkg::POS_WAIT;
        end else if (step) begin
            r_pos <= n_pos;
        end
    end

    // decoded byte store
    always_ff @(posedge i_clk) begin
        if (step && store) begin
            r_bytes[idx] <= n_byte;
        end
    end

    assign xor_all = r_bytes[0] ^ r_bytes[1] ^ r_bytes[2] ^ r_bytes[3] ^ r_bytes[4];

    // result on the end position; bad end byte reports zeros
    always_comb begin
        o_res.valid = step && (r_pos == rfid_hex_pkg::POS_END);
        if (i_beat.rx_byte == rfid_hex_pkg::END_BYTE) begin
            o_res.frame.frame_status = rfid_hex_pkg::STATUS_OK;
            o_res.frame.tag_id       = {r_bytes[1], r_bytes[2], r_bytes[3], r_bytes[4]};
            o_res.frame.xor_check    = xor_all;
        end else begin
            o_res.frame.frame_status = rfid_hex_pkg::STATUS_BAD_END;
            o_res.frame.tag_id       = 32'h0;
            o_res.frame.xor_check    = 8'h0;
        end
    end

endmodule

@@ hdl/rfid_hex_out_reg.sv @@
// result register: holds one frame result until the sink takes it
// depends on rfid_hex_pkg and rfid_hex_frame_if
module rfid_hex_out_reg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rfid_hex_pkg::t_res_beat i_res,
    rfid_hex_frame_if.source        o_frame,
    output logic                    o_advance
);

    logic                 r_valid;
    rfid_hex_pkg::t_frame r_frame;

    // pipeline moves when the result slot is empty or being drained
    assign o_advance = !r_valid || o_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res.valid) begin
            r_frame <= i_res.frame;
        end
    end

    assign o_frame.valid        = r_valid;
    assign o_frame.frame_status = r_frame.frame_status;
    assign o_frame.tag_id       = r_frame.tag_id;
    assign o_frame.xor_check    = r_frame.xor_check;

endmodule

@@ hdl/rfid_ascii_hex_frame_parser_top.sv @@
// A 125 kHz RFID reader byte stream parser. It takes one byte per beat and accepts a new
// beat every cycle as long as the result side is not stalled; a byte passes an input
// register and a result register; the result register presents the result that the
// frame's end byte yields. Bytes are ignored until start byte 0x02, then eleven ASCII hex
// characters are gathered (the eleventh is dropped), and the next byte yields one
// result: status 0 with the 32-bit tag id and the XOR of the five decoded bytes when it
// is 0x03, otherwise status 1 with tag id and XOR at zero. The XOR is reported only.
// depends on rfid_hex_pkg, rfid_hex_byte_if, rfid_hex_frame_if and the three stages
module rfid_ascii_hex_frame_parser_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rfid_hex_byte_if.sink    i_rx,
    rfid_hex_frame_if.source o_frame
);

    rfid_hex_pkg::t_in_beat  in_beat;
    rfid_hex_pkg::t_res_beat res_beat;
    logic                    advance;

    // input byte register
    rfid_hex_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_beat    (in_beat)
    );

    // parse logic and frame state
    rfid_hex_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_beat    (in_beat),
        .o_res     (res_beat)
    );

    // result register
    rfid_hex_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (res_beat),
        .o_frame   (o_frame),
        .o_advance (advance)
    );

endmodule

@@ hdl/rfid_hex_checker.sv @@
// port-level checks for the rfid frame parser, bound to the top level
// depends on rfid_ascii_hex_frame_parser_top_defines.svh and rfid_hex_pkg
`include "rfid_ascii_hex_frame_parser_top_defines.svh"

module rfid_hex_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_status,
    input logic [31:0] i_tag_id,
    input logic [7:0]  i_xor_check
);

    // no result beat right after reset
    `RFID_ASSERT_RESET(a_no_result_after_reset, !i_out_valid)

    // stalled result beat holds
    `RFID_ASSERT_NEXT(a_result_holds, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_status) && $stable(i_tag_id) && $stable(i_xor_check))

    // bad end byte reports zero tag and xor
    `RFID_ASSERT_NOW(a_bad_end_zero,
        i_out_valid && (i_status == rfid_hex_pkg::STATUS_BAD_END),
        (i_tag_id == 32'h0) && (i_xor_check == 8'h0))

    // input side open whenever the result side can move
    `RFID_ASSERT_NOW(a_input_open, !i_out_valid || i_out_ready, i_in_ready)

endmodule

bind rfid_ascii_hex_frame_parser_top rfid_hex_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_status    (o_frame.frame_status),
    .i_tag_id    (o_frame.tag_id),
    .i_xor_check (o_frame.xor_check)
);

@@ tb/sv/tb_rfid_frame_sb_pkg.sv @@
`timescale 1ns / 1ps
// scoreboard for the rfid ascii-hex frame parser: predicts frame results from input beats
// depends on rfid_hex_pkg
package tb_rfid_frame_sb_pkg;
    import rfid_hex_pkg::*;

    class rfid_frame_scoreboard;
        logic [3:0] frame_pos;
        logic [7:0] tag_bytes [BYTE_COUNT];
        t_frame     expected_frames [$];
        int         mismatches;
        int         good_frames;
        int         bad_frames;

        function new();
            frame_pos   = POS_WAIT;
            foreach (tag_bytes[i]) tag_bytes[i] = '0;
            mismatches  = 0;
            good_frames = 0;
            bad_frames  = 0;
        endfunction

        // ascii character to its wrapped nibble value
        function logic [7:0] char_value(input logic [7:0] c);
            if (c > CHAR_NINE) begin
                return c - ALPHA_OFFSET;
            end
            return c - DIGIT_OFFSET;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        // advance the frame tracker by one accepted input beat
        function void note_byte(input logic [7:0] b);
            logic [7:0] nib;
            int         idx;
            t_frame     res;
            logic [7:0] x;
            if (frame_pos < POS_END) begin
                nib = char_value(b);
                idx = int'(frame_pos) >> 1;
                if (idx < BYTE_COUNT) begin
                    if (!frame_pos[0]) begin
                        tag_bytes[idx] = {nib[3:0], 4'h0};
                    end else begin
                        tag_bytes[idx] = tag_bytes[idx] + nib;
                    end
                end
                frame_pos = frame_pos + 4'd1;
            end else if (frame_pos == POS_END) begin
                frame_pos = POS_WAIT;
                if (b != END_BYTE) begin
                    res.frame_status = STATUS_BAD_END;
                    res.tag_id       = '0;
                    res.xor_check    = '0;
                end else begin
                    x = '0;
                    foreach (tag_bytes[i]) x = x ^ tag_bytes[i];
                    res.frame_status = STATUS_OK;
                    res.tag_id       = {tag_bytes[1], tag_bytes[2], tag_bytes[3], tag_bytes[4]};
                    res.xor_check    = x;
                end
                expected_frames.push_back(res);
            end else begin
                // idle, including the unused positions
                frame_pos = (b == START_BYTE) ? POS_FIRST : POS_WAIT;
            end
        endfunction

        function void compare_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
            if (act_v !== exp_v) begin
                mismatches++;
                $display("%0t: frame %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // compare one result beat with the oldest prediction
        function void check_frame(input t_frame got);
            t_frame exp_f;
            if (expected_frames.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected frame result, expected none, actual %0d/%h/%h",
                         $time, got.frame_status, got.tag_id, got.xor_check);
                return;
            end
            exp_f = expected_frames.pop_front();
            if (exp_f.frame_status == STATUS_OK) begin
                good_frames++;
            end else begin
                bad_frames++;
            end
            compare_field("status", 32'(exp_f.frame_status), 32'(got.frame_status));
            compare_field("tag_id", exp_f.tag_id, got.tag_id);
            compare_field("xor", 32'(exp_f.xor_check), 32'(got.xor_check));
        endfunction
    endclass

endpackage

@@ tb/sv/tb_rfid_ascii_hex_frame_parser_top.sv @@
`timescale 1ns / 1ps
// top-level testbench for rfid_ascii_hex_frame_parser_top: directed and random frames
// depends on rfid_hex_pkg, tb_rfid_frame_sb_pkg and the two channel interfaces
module tb_rfid_ascii_hex_frame_parser_top;
    import rfid_hex_pkg::*;
    import tb_rfid_frame_sb_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 500;
    localparam int DRAIN_CYCLES = 10;
    localparam int CHAR_COUNT   = 11;

    typedef logic [7:0] t_chars [CHAR_COUNT];

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   frame_bytes_sent;
    int   noise_bytes_sent;
    int   cycle_count = 0;

    rfid_frame_scoreboard frame_sb;

    rfid_hex_byte_if  rx_if ();
    rfid_hex_frame_if frame_if ();

    rfid_ascii_hex_frame_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, frame_sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side ready, changed at the falling edge
    initial begin
        frame_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            frame_if.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // check each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            frame_sb.check_frame({frame_if.frame_status, frame_if.tag_id, frame_if.xor_check});
        end
    end

    function automatic logic [7:0] hex_char(input int n);
        return (n < 10) ? DIGIT_OFFSET + 8'(n) : ALPHA_OFFSET + 8'(n);
    endfunction

    // one input beat, with random idle cycles ahead of it; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            rx_if.valid = 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do @(posedge i_clk); while (!rx_if.ready);
        frame_sb.note_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_chars chars, input logic [7:0] end_byte);
        send_byte(START_BYTE);
        foreach (chars[i]) send_byte(chars[i]);
        send_byte(end_byte);
        frame_bytes_sent += CHAR_COUNT + 2;
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte(8'($urandom_range(255)));
        noise_bytes_sent += n;
    endtask

    // mostly hex frames with a good end, some raw bytes, repeated digits and bad ends
    task automatic random_frame();
        t_chars     chars;
        int         mode;
        logic [7:0] rep;
        logic [7:0] end_b;
        mode = $urandom_range(9);
        rep  = hex_char($urandom_range(15));
        foreach (chars[i]) begin
            if (mode == 0) begin
                chars[i] = rep;
            end else if (mode == 1 || $urandom_range(9) == 0) begin
                chars[i] = 8'($urandom_range(255));
            end else begin
                chars[i] = hex_char($urandom_range(15));
            end
        end
        end_b = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : END_BYTE;
        send_frame(chars, end_b);
    endtask

    task automatic run_phase(input int target);
        int start_count;
        start_count = frame_bytes_sent;
        while (frame_bytes_sent - start_count < target) begin
            if ($urandom_range(9) < 3) begin
                send_noise($urandom_range(1, 4));
            end
            random_frame();
        end
    endtask

    // stimulus
    initial begin
        t_chars mix_chars;
        t_chars all_f_chars;
        frame_sb         = new();
        frame_bytes_sent = 0;
        noise_bytes_sent = 0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        rx_if.valid      = 1'b0;
        rx_if.rx_byte    = 8'h00;
        i_rst_n          = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct  = 14;
        sink_idle_pct = 77;

        // bytes outside a frame, including an end byte, are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_BYTE);
        // digits, letters, lower case, non-hex and wrapping characters, good end
        mix_chars = '{"0", "9", "A", "F", 8'h00, 8'hFF, "f", ":", "@", START_BYTE, "Z"};
        send_frame(mix_chars, END_BYTE);
        // all-ones tag, then a start byte where the end byte belongs
        foreach (all_f_chars[i]) all_f_chars[i] = "F";
        send_frame(all_f_chars, END_BYTE);
        send_frame(all_f_chars, START_BYTE);

        run_phase(PHASE_BYTES);
        src_idle_pct  = 77;
        sink_idle_pct = 14;
        run_phase(PHASE_BYTES);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_phase(PHASE_BYTES);

        rx_if.valid = 1'b0;
        while (frame_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d frame bytes and %0d stray bytes under three stall mixes",
                 frame_bytes_sent, noise_bytes_sent);
        $display("checked %0d tag reads and %0d bad-end reports, %0d mismatches",
                 frame_sb.good_frames, frame_sb.bad_frames, frame_sb.mismatches);
        if (frame_sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
